@@ src/dpmg_pkg.sv @@
// Shared types and constants for the detector pixel mask generator.
// No dependencies.
`default_nettype none

package dpmg_pkg;

  localparam int FieldW     = 11;   // one packed coordinate field
  localparam int BoxW       = 44;   // four packed fields
  localparam int TriLastW   = 22;   // two packed fields
  localparam int PixW       = 10;   // pixel row / column
  localparam int ModeW      = 5;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 44;
  localparam int MaxSizeDef = 1024;

  localparam logic [FieldW-1:0] SizeReset = 11'd128;

  // mode_bits positions
  localparam int ModeEdgeOn  = 0;
  localparam int ModeEdgeEll = 1;
  localparam int ModeBeamOn  = 2;
  localparam int ModeBeamEll = 3;
  localparam int ModeTrans   = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSize     = 3'd0,
    CfgEdgeBox  = 3'd1,
    CfgBeamBox  = 3'd2,
    CfgMode     = 3'd3,
    CfgRowBand  = 3'd4,
    CfgColBand  = 3'd5,
    CfgTriFirst = 3'd6,
    CfgTriLast  = 3'd7
  } cfg_idx_e;

  // per-pixel decisions settled in the first stage, carried down the pipe
  typedef struct packed {
    logic out_range;
    logic edge_rect_out;
    logic beam_rect_in;
    logic band_hit;
  } flags_t;

endpackage

`default_nettype wire

@@ src/detector_pixel_mask_generator.sv @@
// Detector pixel mask generator: four-stage pipelined mask decision per pixel.
// Depends on dpmg_pkg.
//
// Usage:
//  - Input channel: in_valid_i / in_stall_o with pixel_row_i, pixel_col_i
//    (zero-based). Output channel: out_valid_o / out_stall_i with keep_o
//    (1 = pixel used, 0 = masked). One result per request, in order.
//  - Config: cfg_we_i writes cfg_data_i to register cfg_idx_i on the clock
//    edge; write only while no request is in flight.
//  - Four register stages: differences and box/band compares, squares and
//    triangle products, ellipse products and cross products, final compare
//    and combine into the output register, which each request passes through in order.
//  - Throughput: one request per cycle while in_stall_o is low, set by the
//    fully pipelined multipliers; no iteration anywhere.
//  - Stall: each stage loads when empty or when the stage below moves, so
//    bubbles are squeezed out and requests keep entering while a result
//    waits. in_stall_o rises only when all four stages hold requests and the
//    output is stalled. Nothing is lost or repeated.
//  - Reset: all stage valids clear, config returns to its reset values
//    (detector_size 128, everything else zero).
//  - Config-derived ellipse axis squares and then their products are registered
//    after a write and settle ahead of any request reaching the compare.
`default_nettype none

module detector_pixel_mask_generator #(
  parameter int MAX_SIZE = dpmg_pkg::MaxSizeDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dpmg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dpmg_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [dpmg_pkg::PixW-1:0]     pixel_row_i,
  input  wire logic [dpmg_pkg::PixW-1:0]     pixel_col_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               keep_o
);
  import dpmg_pkg::*;

  localparam logic [FieldW-1:0] MaxSize = FieldW'(MAX_SIZE);

  // ---------------------------------------------------------------- config
  logic [FieldW-1:0]   size_q;
  logic [BoxW-1:0]     edge_box_q, beam_box_q, row_band_q, col_band_q, tri_first_q;
  logic [TriLastW-1:0] tri_last_q;
  logic [ModeW-1:0]    mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SizeReset;
      edge_box_q  <= '0;
      beam_box_q  <= '0;
      mode_q      <= '0;
      row_band_q  <= '0;
      col_band_q  <= '0;
      tri_first_q <= '0;
      tri_last_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgSize:     size_q      <= cfg_data_i[FieldW-1:0];
        CfgEdgeBox:  edge_box_q  <= cfg_data_i[BoxW-1:0];
        CfgBeamBox:  beam_box_q  <= cfg_data_i[BoxW-1:0];
        CfgMode:     mode_q      <= cfg_data_i[ModeW-1:0];
        CfgRowBand:  row_band_q  <= cfg_data_i[BoxW-1:0];
        CfgColBand:  col_band_q  <= cfg_data_i[BoxW-1:0];
        CfgTriFirst: tri_first_q <= cfg_data_i[BoxW-1:0];
        CfgTriLast:  tri_last_q  <= cfg_data_i[TriLastW-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [FieldW-1:0] fld(logic [BoxW-1:0] v, int k);
    return v[FieldW*k +: FieldW];
  endfunction

  // 1-based band test: along1 / across1 are pixel position + 1
  function automatic logic band_test(logic [BoxW-1:0] v, logic [FieldW-1:0] md,
                                     logic [FieldW-1:0] along1,
                                     logic [FieldW-1:0] across1);
    logic [FieldW-1:0] first, last, s, e, lo, hi;
    logic ok;
    first = fld(v, 0);
    last  = fld(v, 1);
    s     = fld(v, 2);
    e     = fld(v, 3);
    ok = (first != '0) && (last != '0) && (first <= md) && (last <= md) &&
         (first <= last);
    lo = ((s != '0) && (s <= md)) ? s : FieldW'(1);
    hi = ((e != '0) && (e <= md)) ? e : md;
    if (lo > hi) begin
      {lo, hi} = {hi, lo};
    end
    return ok && (along1 >= first) && (along1 <= last) &&
           (across1 >= lo) && (across1 <= hi);
  endfunction

  logic [FieldW-1:0] md;
  assign md = (size_q > MaxSize) ? MaxSize : size_q;

  // box fields
  logic [FieldW-1:0] e_lt, e_rb, e_tp, e_bt, b_lt, b_rb, b_tp, b_bt;
  assign e_lt = fld(edge_box_q, 0);
  assign e_rb = fld(edge_box_q, 1);
  assign e_tp = fld(edge_box_q, 2);
  assign e_bt = fld(edge_box_q, 3);
  assign b_lt = fld(beam_box_q, 0);
  assign b_rb = fld(beam_box_q, 1);
  assign b_tp = fld(beam_box_q, 2);
  assign b_bt = fld(beam_box_q, 3);

  // triangle vertices, 1-based
  logic [FieldW-1:0] x1, y1, x2, y2, x3, y3;
  assign x1 = fld(tri_first_q, 0);
  assign y1 = fld(tri_first_q, 1);
  assign x2 = fld(tri_first_q, 2);
  assign y2 = fld(tri_first_q, 3);
  assign x3 = tri_last_q[FieldW-1:0];
  assign y3 = tri_last_q[2*FieldW-1:FieldW];

  function automatic logic coord_ok(logic [FieldW-1:0] v, logic [FieldW-1:0] m);
    return (v != '0) && (v <= m);
  endfunction

  logic tri_valid;
  assign tri_valid = coord_ok(x1, md) && coord_ok(y1, md) && coord_ok(x2, md) &&
                     coord_ok(y2, md) && coord_ok(x3, md) && coord_ok(y3, md) &&
                     !((x1 == x2) && (y1 == y2)) && !((x1 == x3) && (y1 == y3)) &&
                     !((x2 == x3) && (y2 == y3));

  // ellipse axes (sign is irrelevant, only squares are used)
  logic signed [12:0] e_sx, e_sy, b_tx, b_ty;
  assign e_sx = {2'b0, e_rb} - {2'b0, e_lt} + 13'd2;
  assign e_sy = {2'b0, e_bt} - {2'b0, e_tp} + 13'd2;
  assign b_tx = {1'b0, b_rb, 1'b0} - {1'b0, b_lt, 1'b0} + 13'd1;
  assign b_ty = {1'b0, b_bt, 1'b0} - {1'b0, b_tp, 1'b0} + 13'd1;

  // registered axis squares and their products
  logic signed [25:0] sq_sx, sq_sy, sq_tx, sq_ty;
  logic [22:0] sx2_q, sy2_q;
  logic [23:0] tx2_q, ty2_q;
  logic [45:0] sxy_q;
  logic [47:0] txy_q;

  assign sq_sx = e_sx * e_sx;
  assign sq_sy = e_sy * e_sy;
  assign sq_tx = b_tx * b_tx;
  assign sq_ty = b_ty * b_ty;

  always_ff @(posedge clk_i) begin
    sx2_q <= sq_sx[22:0];
    sy2_q <= sq_sy[22:0];
    tx2_q <= sq_tx[23:0];
    ty2_q <= sq_ty[23:0];
    sxy_q <= 46'(sx2_q) * 46'(sy2_q);
    txy_q <= 48'(tx2_q) * 48'(ty2_q);
  end

  // triangle edge vectors
  logic signed [11:0] t_dy21, t_dx21, t_dy32, t_dx32, t_dy13, t_dx13;
  assign t_dy21 = {1'b0, y2} - {1'b0, y1};
  assign t_dx21 = {1'b0, x2} - {1'b0, x1};
  assign t_dy32 = {1'b0, y3} - {1'b0, y2};
  assign t_dx32 = {1'b0, x3} - {1'b0, x2};
  assign t_dy13 = {1'b0, y1} - {1'b0, y3};
  assign t_dx13 = {1'b0, x1} - {1'b0, x3};

  // --------------------------------------------------------- flow control
  logic va_q, vb_q, vc_q, vo_q;
  logic adv_o, adv_c, adv_b, adv_a;

  assign adv_o = !vo_q || !out_stall_i;
  assign adv_c = !vc_q || adv_o;
  assign adv_b = !vb_q || adv_c;
  assign adv_a = !va_q || adv_b;
  assign in_stall_o  = !adv_a;
  assign out_valid_o = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv_a) va_q <= in_valid_i;
      if (adv_b) vb_q <= va_q;
      if (adv_c) vc_q <= vb_q;
      if (adv_o) vo_q <= vc_q;
    end
  end

  // ------------------------------------------- stage A: offsets, compares
  logic [FieldW-1:0] r1, c1;
  assign r1 = {1'b0, pixel_row_i} + FieldW'(1);
  assign c1 = {1'b0, pixel_col_i} + FieldW'(1);

  flags_t fl_d, fa_q, fb_q, fc_q;
  always_comb begin
    fl_d.out_range     = ({1'b0, pixel_row_i} >= md) || ({1'b0, pixel_col_i} >= md);
    fl_d.edge_rect_out = (r1 < e_tp) || (r1 > e_bt) || (c1 < e_lt) || (c1 > e_rb);
    fl_d.beam_rect_in  = (r1 >= b_tp) && (r1 <= b_bt) && (c1 >= b_lt) && (c1 <= b_rb);
    fl_d.band_hit      = band_test(row_band_q, md, r1, c1) ||
                         band_test(col_band_q, md, c1, r1);
  end

  // doubled offsets from box centers
  logic signed [13:0] e_dx_d, e_dy_d, b_dx_d, b_dy_d, e_dx_q, e_dy_q, b_dx_q, b_dy_q;
  assign e_dx_d = {3'b0, e_lt} + {3'b0, e_rb} - 14'd2 - {3'b0, pixel_col_i, 1'b0};
  assign e_dy_d = {3'b0, e_tp} + {3'b0, e_bt} - 14'd2 - {3'b0, pixel_row_i, 1'b0};
  assign b_dx_d = {3'b0, b_lt} + {3'b0, b_rb} - 14'd2 - {3'b0, pixel_col_i, 1'b0};
  assign b_dy_d = {3'b0, b_tp} + {3'b0, b_bt} - 14'd2 - {3'b0, pixel_row_i, 1'b0};

  // vertex minus pixel
  logic signed [11:0] ex1_q, ey1_q, ex2_q, ey2_q, ex3_q, ey3_q;

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      fa_q   <= fl_d;
      e_dx_q <= e_dx_d;
      e_dy_q <= e_dy_d;
      b_dx_q <= b_dx_d;
      b_dy_q <= b_dy_d;
      ex1_q  <= {1'b0, x1} - {1'b0, c1};
      ey1_q  <= {1'b0, y1} - {1'b0, r1};
      ex2_q  <= {1'b0, x2} - {1'b0, c1};
      ey2_q  <= {1'b0, y2} - {1'b0, r1};
      ex3_q  <= {1'b0, x3} - {1'b0, c1};
      ey3_q  <= {1'b0, y3} - {1'b0, r1};
    end
  end

  // ---------------------------------- stage B: squares, triangle products
  logic signed [27:0] sq_edx, sq_edy, sq_bdx, sq_bdy;
  assign sq_edx = e_dx_q * e_dx_q;
  assign sq_edy = e_dy_q * e_dy_q;
  assign sq_bdx = b_dx_q * b_dx_q;
  assign sq_bdy = b_dy_q * b_dy_q;

  logic [23:0] edx2_q, edy2_q, bdx2_q, bdy2_q;
  logic signed [23:0] pa1_q, pa2_q, pb1_q, pb2_q, pc1_q, pc2_q;

  always_ff @(posedge clk_i) begin
    if (adv_b) begin
      fb_q   <= fa_q;
      edx2_q <= sq_edx[23:0];
      edy2_q <= sq_edy[23:0];
      bdx2_q <= sq_bdx[23:0];
      bdy2_q <= sq_bdy[23:0];
      pa1_q  <= ex1_q * t_dy21;
      pa2_q  <= t_dx21 * ey1_q;
      pb1_q  <= ex2_q * t_dy32;
      pb2_q  <= t_dx32 * ey2_q;
      pc1_q  <= ex3_q * t_dy13;
      pc2_q  <= t_dx13 * ey3_q;
    end
  end

  // ------------------------- stage C: ellipse products, cross products
  logic [46:0] ep1_q, ep2_q;
  logic [47:0] bp1_q, bp2_q;
  logic [24:0] cr_a_q, cr_b_q, cr_c_q;

  always_ff @(posedge clk_i) begin
    if (adv_c) begin
      fc_q   <= fb_q;
      ep1_q  <= 47'(edx2_q) * 47'(sy2_q);
      ep2_q  <= 47'(edy2_q) * 47'(sx2_q);
      bp1_q  <= 48'(bdx2_q) * 48'(ty2_q);
      bp2_q  <= 48'(bdy2_q) * 48'(tx2_q);
      cr_a_q <= {pa1_q[23], pa1_q} - {pa2_q[23], pa2_q};
      cr_b_q <= {pb1_q[23], pb1_q} - {pb2_q[23], pb2_q};
      cr_c_q <= {pc1_q[23], pc1_q} - {pc2_q[23], pc2_q};
    end
  end

  // ------------------------------------- output stage: compare, combine
  logic [47:0] e_sum;
  logic [48:0] b_sum;
  logic edge_out, beam_in, tri_hit, keep_d, keep_q;
  logic a_nn, b_nn, c_nn, a_np, b_np, c_np;

  always_comb begin
    e_sum = {1'b0, ep1_q} + {1'b0, ep2_q};
    b_sum = {1'b0, bp1_q} + {1'b0, bp2_q};
    edge_out = mode_q[ModeEdgeEll] ? (e_sum > {2'b0, sxy_q}) : fc_q.edge_rect_out;
    beam_in  = mode_q[ModeBeamEll] ? ({b_sum, 2'b00} <= {3'b0, txy_q}) :
                                     fc_q.beam_rect_in;
    a_nn = !cr_a_q[24];
    b_nn = !cr_b_q[24];
    c_nn = !cr_c_q[24];
    a_np = cr_a_q[24] || (cr_a_q == '0);
    b_np = cr_b_q[24] || (cr_b_q == '0);
    c_np = cr_c_q[24] || (cr_c_q == '0);
    tri_hit = tri_valid && ((a_nn && b_nn && c_nn) || (a_np && b_np && c_np));
    priority if (fc_q.out_range) begin
      keep_d = 1'b0;
    end else if (mode_q[ModeTrans]) begin
      keep_d = mode_q[ModeBeamOn] && beam_in;
    end else begin
      keep_d = !(mode_q[ModeEdgeOn] && edge_out) && !(mode_q[ModeBeamOn] && beam_in) &&
               !fc_q.band_hit && !tri_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      keep_q <= keep_d;
    end
  end

  assign keep_o = keep_q;

  // ------------------------------------------------------------ checks
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (va_q && vb_q && vc_q && vo_q && out_stall_i))
    else $error("input stalled while the pipeline has a free slot");

  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> va_q)
    else $error("accepted request did not enter stage A");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !vc_q) |=> !out_valid_o)
    else $error("result repeated after being taken");

endmodule

`default_nettype wire
